FILE: hw/rtl/key_press_repeat_event_generator_defines.svh
// Assertion macros shared by the key event generator RTL.
// No dependencies; included by the top level only.
`ifndef KEY_PRESS_REPEAT_EVENT_GENERATOR_DEFINES_SVH
`define KEY_PRESS_REPEAT_EVENT_GENERATOR_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define KPRG_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define KPRG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/kprg_pkg.sv
// Shared types and codes for the key event generator.
// No dependencies; imported by all RTL modules.
package kprg_pkg;

    localparam int CMD_W   = 2;
    localparam int BTN_W   = 3;
    localparam int EVT_W   = 3;
    localparam int PHASE_W = 16;
    localparam int PER_W   = 9;
    localparam int LP_W    = 8;
    localparam int CFG_IW  = 2;
    localparam int CFG_DW  = 16;

    localparam logic [CMD_W-1:0] CMD_TICK = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DOWN = 2'd1;
    localparam logic [CMD_W-1:0] CMD_UP   = 2'd2;

    localparam logic [EVT_W-1:0] EV_PRESS   = 3'd0;
    localparam logic [EVT_W-1:0] EV_RELEASE = 3'd1;
    localparam logic [EVT_W-1:0] EV_SHORT   = 3'd2;
    localparam logic [EVT_W-1:0] EV_LONG    = 3'd3;
    localparam logic [EVT_W-1:0] EV_REPEAT  = 3'd4;

    localparam logic [CFG_IW-1:0] REG_PERIOD_TICKS = 2'd0;
    localparam logic [CFG_IW-1:0] REG_LONG_PERIODS = 2'd1;
    localparam logic [CFG_IW-1:0] REG_EVENTS_EN    = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_RUN   = 3'b010,
        ST_FLUSH = 3'b100
    } state_t;

    typedef struct packed {
        logic load_in;
        logic key_apply;
        logic scan_step;
        logic flush;
    } ctrl_cmd_t;

    typedef struct packed {
        logic cmd_tick;
        logic key_act;
        logic key_emit;
        logic scan_ev;
        logic scan_last;
        logic pend_valid;
        logic out_free;
    } dp_status_t;

endpackage

FILE: hw/rtl/kprg_ctrl.sv
// Sequencer for the key event generator: accepts an item, runs a key
// update or a button scan, and after a scan flushes the held-back event. Uses kprg_pkg.
module kprg_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  kprg_pkg::dp_status_t st,
    output kprg_pkg::ctrl_cmd_t  cmd_o
);
    import kprg_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   step_ok;

    // A found event may only enter the pending slot once the old one can leave.
    assign step_ok = !st.scan_ev || !st.pend_valid || st.out_free;

    always_comb
    begin
        state_next      = state_reg;
        cmd_o.load_in   = 1'b0;
        cmd_o.key_apply = 1'b0;
        cmd_o.scan_step = 1'b0;
        cmd_o.flush     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_o.load_in = 1'b1;
                    state_next    = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (st.cmd_tick)
                begin
                    if (step_ok)
                    begin
                        cmd_o.scan_step = 1'b1;
                        if (st.scan_last)
                            state_next = ST_FLUSH;
                    end
                end
                else if (st.key_act)
                begin
                    if (!st.key_emit || st.out_free)
                    begin
                        cmd_o.key_apply = 1'b1;
                        state_next      = ST_IDLE;
                    end
                end
                else
                    state_next = ST_IDLE;
            end
            ST_FLUSH:
            begin
                if (!st.pend_valid)
                    state_next = ST_IDLE;
                else if (st.out_free)
                begin
                    cmd_o.flush = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    assign in_stall = (state_reg != ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

FILE: hw/rtl/kprg_dp.sv
// Datapath of the key event generator: settings registers, per-button
// hold timers, scan index, pending event and output register. Uses kprg_pkg.
module kprg_dp #(
    parameter int NUM_BUTTONS = 6
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    input  logic [kprg_pkg::CFG_IW-1:0]   cfg_index,
    input  logic [kprg_pkg::CFG_DW-1:0]   cfg_data,
    input  logic [kprg_pkg::CMD_W-1:0]    cmd,
    input  logic [kprg_pkg::BTN_W-1:0]    button,
    input  logic                          out_stall,
    output logic                          out_valid,
    output logic [kprg_pkg::BTN_W-1:0]    button_out,
    output logic [kprg_pkg::EVT_W-1:0]    event_type,
    output logic                          last,
    input  kprg_pkg::ctrl_cmd_t           cmd_i,
    output kprg_pkg::dp_status_t          st
);
    import kprg_pkg::*;

    localparam int IW = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
    localparam int XW = (IW > BTN_W) ? IW : BTN_W;
    localparam logic [4:0]    NB       = 5'(NUM_BUTTONS);
    localparam logic [IW-1:0] LAST_IDX = IW'(NUM_BUTTONS - 1);

    logic [PHASE_W-1:0] period_ticks_reg;
    logic [LP_W-1:0]    long_periods_reg;
    logic               events_en_reg;

    logic [CMD_W-1:0]   cmd_reg;
    logic [BTN_W-1:0]   btn_reg;
    logic [IW-1:0]      scan_idx_reg;

    logic               held_reg   [NUM_BUTTONS];
    logic [PHASE_W-1:0] phase_reg  [NUM_BUTTONS];
    logic [PER_W-1:0]   period_reg [NUM_BUTTONS];

    logic               pend_valid_reg;
    logic               pend_valid_next;
    logic [BTN_W-1:0]   pend_btn_reg;
    logic [BTN_W-1:0]   pend_btn_next;
    logic [EVT_W-1:0]   pend_type_reg;
    logic [EVT_W-1:0]   pend_type_next;

    logic               out_valid_reg;
    logic               out_valid_next;
    logic [BTN_W-1:0]   out_btn_reg;
    logic [BTN_W-1:0]   out_btn_next;
    logic [EVT_W-1:0]   out_type_reg;
    logic [EVT_W-1:0]   out_type_next;
    logic               out_last_reg;
    logic               out_last_next;
    logic               out_load;

    logic [XW-1:0]      btn_x;
    logic [XW-1:0]      scan_x;
    logic [IW-1:0]      key_idx;
    logic [IW-1:0]      rd_idx;
    logic               rd_held;
    logic [PHASE_W-1:0] rd_phase;
    logic [PER_W-1:0]   rd_period;
    logic [PHASE_W-1:0] per;
    logic [PHASE_W:0]   phase_inc;
    logic               wrap;
    logic               cmd_tick;
    logic               cmd_key;
    logic               in_range;
    logic               key_act;
    logic               scan_ev;
    logic [EVT_W-1:0]   scan_type;
    logic [PER_W-1:0]   lp_x;

    assign cmd_tick = (cmd_reg == CMD_TICK);
    assign cmd_key  = (cmd_reg == CMD_DOWN) || (cmd_reg == CMD_UP);
    assign in_range = ({2'b00, btn_reg} < NB);

    assign btn_x   = XW'(btn_reg);
    assign key_idx = btn_x[IW-1:0];
    assign scan_x  = XW'(scan_idx_reg);
    assign rd_idx  = cmd_tick ? scan_idx_reg : key_idx;

    assign rd_held   = held_reg[rd_idx];
    assign rd_phase  = phase_reg[rd_idx];
    assign rd_period = period_reg[rd_idx];

    // A zero period acts as one tick.
    assign per       = (period_ticks_reg == '0) ? PHASE_W'(1) : period_ticks_reg;
    assign phase_inc = {1'b0, rd_phase} + (PHASE_W+1)'(1);
    assign wrap      = (phase_inc >= {1'b0, per});
    assign lp_x      = {1'b0, long_periods_reg};

    assign key_act = cmd_key && in_range &&
                     !((cmd_reg == CMD_DOWN) && rd_held);

    assign scan_ev = rd_held && (rd_phase == '0) && (rd_period != '0) && events_en_reg;

    always_comb
    begin
        if (rd_period < lp_x)
            scan_type = EV_SHORT;
        else if (rd_period == lp_x)
            scan_type = EV_LONG;
        else
            scan_type = EV_REPEAT;
    end

    // Status toward the sequencer
    assign st.cmd_tick   = cmd_tick;
    assign st.key_act    = key_act;
    assign st.key_emit   = events_en_reg;
    assign st.scan_ev    = scan_ev;
    assign st.scan_last  = (scan_idx_reg == LAST_IDX);
    assign st.pend_valid = pend_valid_reg;
    assign st.out_free   = !out_valid_reg || !out_stall;

    // Pending slot and output register: key events go straight out; a scan event
    // waits in the slot until the next one shows up (then it leaves with last clear) or the scan ends.
    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        pend_btn_next   = pend_btn_reg;
        pend_type_next  = pend_type_reg;
        out_load        = 1'b0;
        out_btn_next    = out_btn_reg;
        out_type_next   = out_type_reg;
        out_last_next   = out_last_reg;

        if (cmd_i.key_apply && events_en_reg)
        begin
            out_load      = 1'b1;
            out_btn_next  = btn_reg;
            out_type_next = (cmd_reg == CMD_DOWN) ? EV_PRESS : EV_RELEASE;
            out_last_next = 1'b1;
        end

        if (cmd_i.scan_step && scan_ev)
        begin
            if (pend_valid_reg)
            begin
                out_load      = 1'b1;
                out_btn_next  = pend_btn_reg;
                out_type_next = pend_type_reg;
                out_last_next = 1'b0;
            end
            pend_valid_next = 1'b1;
            pend_btn_next   = scan_x[BTN_W-1:0];
            pend_type_next  = scan_type;
        end

        if (cmd_i.flush)
        begin
            out_load        = 1'b1;
            out_btn_next    = pend_btn_reg;
            out_type_next   = pend_type_reg;
            out_last_next   = 1'b1;
            pend_valid_next = 1'b0;
        end

        out_valid_next = out_load || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_ticks_reg <= PHASE_W'(100);
            long_periods_reg <= LP_W'(5);
            events_en_reg    <= 1'b1;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_PERIOD_TICKS: period_ticks_reg <= cfg_data;
                REG_LONG_PERIODS: long_periods_reg <= cfg_data[LP_W-1:0];
                REG_EVENTS_EN:    events_en_reg    <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            scan_idx_reg   <= '0;
            for (int i = 0; i < NUM_BUTTONS; i++)
            begin
                held_reg[i]   <= 1'b0;
                phase_reg[i]  <= '0;
                period_reg[i] <= '0;
            end
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            if (cmd_i.load_in)
                scan_idx_reg <= '0;
            else if (cmd_i.scan_step)
                scan_idx_reg <= scan_idx_reg + IW'(1);

            if (cmd_i.key_apply)
            begin
                held_reg[key_idx]   <= (cmd_reg == CMD_DOWN);
                phase_reg[key_idx]  <= '0;
                period_reg[key_idx] <= '0;
            end
            else if (cmd_i.scan_step && rd_held)
            begin
                // Advance the phase; on wrap bump the period count unless saturated.
                if (wrap)
                begin
                    phase_reg[scan_idx_reg] <= '0;
                    if (rd_period <= lp_x)
                        period_reg[scan_idx_reg] <= rd_period + PER_W'(1);
                end
                else
                    phase_reg[scan_idx_reg] <= phase_inc[PHASE_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_i.load_in)
        begin
            cmd_reg <= cmd;
            btn_reg <= button;
        end
        pend_btn_reg  <= pend_btn_next;
        pend_type_reg <= pend_type_next;
        out_btn_reg   <= out_btn_next;
        out_type_reg  <= out_type_next;
        out_last_reg  <= out_last_next;
    end

    assign out_valid  = out_valid_reg;
    assign button_out = out_btn_reg;
    assign event_type = out_type_reg;
    assign last       = out_last_reg;

endmodule

FILE: hw/rtl/key_press_repeat_event_generator.sv
// Top level of the key event generator: sequencer plus datapath.
// Depends on kprg_pkg, kprg_ctrl, kprg_dp and the assertion macro header.
//
// Turns key-down, key-up and tick items for NUM_BUTTONS buttons into press,
// release, short, long and repeat events; last marks the final event of an
// item. One item is worked on at a time; a key item waits in the run state
// while its event cannot enter the stalled output. A tick scans the hold timers
// one button per cycle through a single timer update unit, pausing while a found
// event meets a full pending slot and a stalled output, then flushes the held-back
// event. The event register lets a finished event sit on the output while the
// next item is already being worked on. Settings are written through the cfg port
// (always ready); the user must write them only while idle, which the block does not enforce.
`include "key_press_repeat_event_generator_defines.svh"

module key_press_repeat_event_generator #(
    parameter int NUM_BUTTONS = 6
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [kprg_pkg::CFG_IW-1:0]   cfg_index,
    input  logic [kprg_pkg::CFG_DW-1:0]   cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [kprg_pkg::CMD_W-1:0]    cmd,
    input  logic [kprg_pkg::BTN_W-1:0]    button,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [kprg_pkg::BTN_W-1:0]    button_out,
    output logic [kprg_pkg::EVT_W-1:0]    event_type,
    output logic                          last
);
    import kprg_pkg::*;

    ctrl_cmd_t  ctrl_cmd;
    dp_status_t dp_st;

    assign cfg_ready = 1'b1;

    kprg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .st       (dp_st),
        .cmd_o    (ctrl_cmd)
    );

    kprg_dp #(
        .NUM_BUTTONS (NUM_BUTTONS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .cmd        (cmd),
        .button     (button),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .button_out (button_out),
        .event_type (event_type),
        .last       (last),
        .cmd_i      (ctrl_cmd),
        .st         (dp_st)
    );

    // One item at a time: an accepted beat blocks the input on the next cycle.
    `KPRG_ASSERT_NEXT(a_accept_blocks, in_valid && !in_stall, in_stall,
                      "input taken twice in a row")
    // Press and release are always the only event of their item.
    `KPRG_ASSERT_SAME(a_key_is_last,
                      out_valid && (event_type == EV_PRESS || event_type == EV_RELEASE),
                      last, "key event without last")
    // A non-final event means its tick is still being worked on.
    `KPRG_ASSERT_SAME(a_mid_busy, out_valid && !last, in_stall,
                      "non-final event while idle")
    // Never scan a button and apply a key update in the same cycle.
    `KPRG_ASSERT_NEXT(a_ctrl_apply, ctrl_cmd.scan_step && ctrl_cmd.key_apply, 1'b0,
                      "scan and key update at once")

endmodule

FILE: bench/tb_key_press_repeat_event_generator.sv
// Self-checking bench for the key event generator: directed and randomized key and tick beats
// against an in-bench prediction of press, release, short, long and repeat events.
// Depends on kprg_pkg and key_press_repeat_event_generator.
`timescale 1ns / 1ps

module tb_key_press_repeat_event_generator;

    import kprg_pkg::*;

    localparam int NUM_BTN       = 6;
    localparam int SETTLE_CYCLES = 24;
    localparam int END_CYCLES    = 40;
    localparam int HOLD_CYCLES   = 300;
    localparam int CYCLE_LIMIT   = 400000;

    localparam logic [CMD_W-1:0]  CMD_BAD   = 2'd3;
    localparam logic [CFG_IW-1:0] REG_SPARE = 2'd3;

    typedef struct packed {
        logic             pause;
        logic [CMD_W-1:0] cmd;
        logic [BTN_W-1:0] btn;
    } key_item_t;

    typedef struct packed {
        logic [BTN_W-1:0] btn;
        logic [EVT_W-1:0] evt;
        logic             last;
    } key_event_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [CFG_IW-1:0] cfg_index = '0;
    logic [CFG_DW-1:0] cfg_data = '0;

    logic             in_valid = 1'b0;
    logic             in_stall;
    logic [CMD_W-1:0] cmd = CMD_TICK;
    logic [BTN_W-1:0] button = '0;

    logic             out_valid;
    logic             out_stall = 1'b1;
    logic [BTN_W-1:0] button_out;
    logic [EVT_W-1:0] event_type;
    logic             last;

    // Predicted state of the keypad and the settings it runs with
    logic                btn_held   [NUM_BTN];
    logic [PHASE_W-1:0]  phase_cnt  [NUM_BTN];
    logic [PER_W-1:0]    period_cnt [NUM_BTN];
    logic [CFG_DW-1:0]   cfg_period    = 16'd100;
    logic [LP_W-1:0]     cfg_long      = 8'd5;
    logic                cfg_events_on = 1'b1;

    key_item_t  pending [$];
    key_event_t events_due [$];

    int queued_items   = 0;
    int accepted_items = 0;
    int fail_count     = 0;
    int send_idle_pct  = 36;
    int recv_idle_pct  = 82;

    logic hold_kick = 1'b0;
    logic hold_seen = 1'b0;
    int   hold_left = 0;

    key_press_repeat_event_generator #(
        .NUM_BUTTONS(NUM_BTN)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cmd       (cmd),
        .button    (button),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .button_out(button_out),
        .event_type(event_type),
        .last      (last)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial
    begin
        for (int i = 0; i < NUM_BTN; i++)
        begin
            btn_held[i]   = 1'b0;
            phase_cnt[i]  = '0;
            period_cnt[i] = '0;
        end
    end

    // Update the hold timers for one accepted beat and queue the events it causes.
    task automatic predict_key_events(input logic [CMD_W-1:0] c, input logic [BTN_W-1:0] b);
        key_event_t ev [NUM_BTN];
        int         n;
        logic [16:0] span;
        n = 0;
        if (c == CMD_TICK)
        begin
            span = (cfg_period == 0) ? 17'd1 : {1'b0, cfg_period};
            for (int i = 0; i < NUM_BTN; i++)
            begin
                if (btn_held[i])
                begin
                    if (phase_cnt[i] == 0 && period_cnt[i] != 0 && cfg_events_on)
                    begin
                        ev[n].btn  = BTN_W'(i);
                        ev[n].evt  = (period_cnt[i] < cfg_long)  ? EV_SHORT :
                                     (period_cnt[i] == cfg_long) ? EV_LONG  : EV_REPEAT;
                        ev[n].last = 1'b0;
                        n++;
                    end
                    if ({1'b0, phase_cnt[i]} + 17'd1 >= span)
                    begin
                        phase_cnt[i] = '0;
                        // saturate one above the long count
                        if (period_cnt[i] <= cfg_long)
                            period_cnt[i] = period_cnt[i] + 1'b1;
                    end
                    else
                    begin
                        phase_cnt[i] = phase_cnt[i] + 1'b1;
                    end
                end
            end
        end
        else if ((c == CMD_DOWN || c == CMD_UP) && b < NUM_BTN
                 && !(c == CMD_DOWN && btn_held[b]))
        begin
            phase_cnt[b]  = '0;
            period_cnt[b] = '0;
            btn_held[b]   = (c == CMD_DOWN);
            if (cfg_events_on)
            begin
                ev[0].btn  = b;
                ev[0].evt  = (c == CMD_DOWN) ? EV_PRESS : EV_RELEASE;
                ev[0].last = 1'b0;
                n = 1;
            end
        end
        for (int k = 0; k < n; k++)
        begin
            ev[k].last = (k == n - 1);
            events_due.push_back(ev[k]);
        end
    endtask

    // Input side: predict on every accepted beat, then offer the next pending item.
    always @(posedge clk)
    begin : key_driver
        logic      offer;
        key_item_t nxt;
        if (in_valid && !in_stall)
        begin
            predict_key_events(cmd, button);
            accepted_items++;
        end
        if (!in_valid || !in_stall)
        begin
            offer = 1'b0;
            nxt   = '0;
            if (pending.size() != 0 && pending[0].pause)
            begin
                // hold off until the output side has drained
                if (events_due.size() == 0)
                    pending.delete(0);
            end
            else if (pending.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                nxt   = pending.pop_front();
                offer = 1'b1;
            end
            in_valid <= offer;
            if (offer)
            begin
                cmd    <= nxt.cmd;
                button <= nxt.btn;
            end
        end
    end

    // Long receiver hold-off, restarted whenever hold_kick toggles
    always @(posedge clk)
    begin
        if (hold_kick != hold_seen)
        begin
            hold_seen <= hold_kick;
            hold_left <= HOLD_CYCLES;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    // Output side: compare every accepted event beat with the oldest prediction.
    always @(posedge clk)
    begin : event_monitor
        key_event_t want;
        if (out_valid && !out_stall)
        begin
            if (events_due.size() == 0)
            begin
                $error("unexpected event: button_out %0d event_type %0d last %0d",
                       button_out, event_type, last);
                fail_count++;
            end
            else
            begin
                want = events_due.pop_front();
                if (button_out !== want.btn)
                begin
                    $error("button_out: expected %0d, got %0d", want.btn, button_out);
                    fail_count++;
                end
                if (event_type !== want.evt)
                begin
                    $error("event_type: expected %0d, got %0d", want.evt, event_type);
                    fail_count++;
                end
                if (last !== want.last)
                begin
                    $error("last: expected %0d, got %0d", want.last, last);
                    fail_count++;
                end
            end
        end
        out_stall <= (hold_left != 0) || ($urandom_range(99) < recv_idle_pct);
    end

    task automatic queue_item(input logic [CMD_W-1:0] c, input logic [BTN_W-1:0] b);
        key_item_t it;
        it.pause = 1'b0;
        it.cmd   = c;
        it.btn   = b;
        pending.push_back(it);
        queued_items++;
    endtask

    task automatic queue_ticks(input int count);
        for (int k = 0; k < count; k++)
            queue_item(CMD_TICK, BTN_W'($urandom));
    endtask

    task automatic queue_pause();
        key_item_t it;
        it       = '0;
        it.pause = 1'b1;
        pending.push_back(it);
    endtask

    // Mostly press / hold-with-ticks / release traffic, with a little noise.
    task automatic queue_random(input int count);
        int r;
        for (int k = 0; k < count; k++)
        begin
            r = $urandom_range(99);
            if (r < 55)
                queue_item(CMD_TICK, BTN_W'($urandom));
            else if (r < 75)
                queue_item(CMD_DOWN, BTN_W'($urandom_range(NUM_BTN - 1)));
            else if (r < 93)
                queue_item(CMD_UP, BTN_W'($urandom_range(NUM_BTN - 1)));
            else if (r < 96)
                queue_item(CMD_BAD, BTN_W'($urandom));
            else
                queue_item(($urandom_range(1) != 0) ? CMD_DOWN : CMD_UP,
                           BTN_W'($urandom_range(7, NUM_BTN)));
        end
    endtask

    // Wait until every item is in and every event is out, then let the block finish.
    task automatic settle();
        do
            @(negedge clk);
        while (pending.size() != 0 || accepted_items != queued_items
               || events_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_PERIOD_TICKS: cfg_period    = val;
            REG_LONG_PERIODS: cfg_long      = val[LP_W-1:0];
            REG_EVENTS_EN:    cfg_events_on = val[0];
            default: ;
        endcase
    endtask

    task automatic close_writes();
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    initial
    begin : stimulus
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset settings
        queue_item(CMD_DOWN, 3'd3);
        queue_item(CMD_TICK, 3'd0);
        queue_item(CMD_UP, 3'd3);
        settle();

        write_reg(REG_PERIOD_TICKS, 16'd1);
        write_reg(REG_LONG_PERIODS, 16'h3C02);
        close_writes();
        queue_item(CMD_DOWN, 3'd0);
        queue_item(CMD_DOWN, 3'd0);       // already held: dropped
        queue_ticks(4);                   // none, short, long, repeat
        queue_item(CMD_DOWN, 3'd5);
        queue_item(CMD_UP, 3'd7);         // out of range
        queue_item(CMD_DOWN, 3'd6);       // out of range
        queue_item(CMD_BAD, 3'd5);
        queue_ticks(1);
        for (int b = 1; b < 5; b++)
            queue_item(CMD_DOWN, BTN_W'(b));
        queue_ticks(2);
        queue_item(CMD_UP, 3'd2);
        queue_item(CMD_UP, 3'd2);         // release of a button that is up
        queue_item(CMD_TICK, 3'd7);
        queue_ticks(1);
        queue_item(CMD_UP, 3'd0);
        settle();

        // events off: counting goes on silently
        write_reg(REG_EVENTS_EN, 16'hA5A4);
        write_reg(REG_PERIOD_TICKS, 16'd3);
        close_writes();
        queue_ticks(4);
        queue_item(CMD_DOWN, 3'd0);
        queue_ticks(3);
        queue_item(CMD_UP, 3'd5);
        queue_item(CMD_DOWN, 3'd2);
        queue_ticks(2);
        settle();
        write_reg(REG_EVENTS_EN, 16'd1);
        close_writes();
        queue_ticks(4);
        settle();

        // zero period and zero long count
        write_reg(REG_PERIOD_TICKS, 16'd0);
        write_reg(REG_LONG_PERIODS, 16'd0);
        close_writes();
        queue_ticks(3);
        queue_item(CMD_UP, 3'd1);
        queue_item(CMD_DOWN, 3'd5);
        queue_ticks(2);
        settle();

        // shrink the period under buttons that are deep into a long one
        write_reg(REG_PERIOD_TICKS, 16'd40);
        write_reg(REG_LONG_PERIODS, 16'd2);
        close_writes();
        queue_ticks(20);
        settle();
        write_reg(REG_PERIOD_TICKS, 16'd5);
        close_writes();
        queue_ticks(3);
        settle();

        // lower the long count below periods already counted
        write_reg(REG_PERIOD_TICKS, 16'd1);
        write_reg(REG_LONG_PERIODS, 16'd9);
        close_writes();
        queue_ticks(12);
        settle();
        write_reg(REG_LONG_PERIODS, 16'd3);
        close_writes();
        queue_ticks(3);
        settle();

        // widest settings
        write_reg(REG_PERIOD_TICKS, 16'hFFFF);
        write_reg(REG_LONG_PERIODS, 16'd255);
        write_reg(REG_SPARE, 16'h5A5A);
        close_writes();
        queue_random(24);

        for (int p = 0; p < 6; p++)
        begin
            settle();
            write_reg(REG_PERIOD_TICKS, CFG_DW'($urandom_range(5, 1)));
            write_reg(REG_LONG_PERIODS, CFG_DW'($urandom_range(4)));
            write_reg(REG_EVENTS_EN, 16'd1);
            close_writes();
            case (p / 2)
                0:
                begin
                    send_idle_pct = 36;
                    recv_idle_pct = 82;
                end
                1:
                begin
                    send_idle_pct = 82;
                    recv_idle_pct = 36;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            if (p == 4)
                hold_kick = ~hold_kick;
            if (p == 2)
            begin
                queue_random(22);
                queue_pause();
                queue_random(23);
            end
            else
            begin
                queue_random(45);
            end
        end

        do
            @(negedge clk);
        while (pending.size() != 0 || accepted_items != queued_items);
        while (events_due.size() != 0)
            @(negedge clk);
        repeat (END_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin : watchdog
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/kprg_pkg.sv
hw/rtl/kprg_ctrl.sv
hw/rtl/kprg_dp.sv
hw/rtl/key_press_repeat_event_generator.sv
bench/tb_key_press_repeat_event_generator.sv
